// File: rtl/core/sha1bs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1bs_pkg
// Shared types and constants of the SHA-1 byte stream hasher: round
// constants, initial chaining values, field widths and action codes.
// ============================================================================

package sha1bs_pkg;

   typedef logic [31:0] word_type;

   // Field widths on the stream ports
   localparam int DATA_BYTE_W   = 8;
   localparam int WORD_INDEX_W  = 3;
   localparam int RSP_TDATA_W   = 40;
   localparam int CHAIN_WORDS   = 5;
   localparam int ROUNDS        = 80;
   localparam int COUNT_W       = 61;

   // Action codes carried on req_tuser
   localparam logic ACTION_ABSORB_C = 1'b0;
   localparam logic ACTION_FINISH_C = 1'b1;

   // Index of the final digest word
   localparam logic [WORD_INDEX_W-1:0] LAST_INDEX_C = 3'd4;

   // Padding marker byte
   localparam logic [DATA_BYTE_W-1:0] PAD_BYTE_C = 8'h80;

   // Round constants, one per group of twenty rounds
   localparam word_type K0_C = 32'h5a827999;
   localparam word_type K1_C = 32'h6ed9eba1;
   localparam word_type K2_C = 32'h8f1bbcdc;
   localparam word_type K3_C = 32'hca62c1d6;

   // Initial chaining values H0..H4
   localparam word_type H_INIT_C [CHAIN_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

endpackage

// File: rtl/core/sha1_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1_byte_stream_hasher_unit
// Streaming SHA-1 hasher: absorbs one message byte per item and emits the
// five-word digest on a finish item.
// ============================================================================
//
// Usage:
//   req channel: req_tuser selects the action (absorb or finish), req_tdata
//   carries the message byte. req_tready is high only while the unit is idle.
//   rsp channel: five digest words, H0 first, with the word index beside the
//   word in rsp_tdata; rsp_tlast marks the fifth word.
// Sequencing:
//   Absorb items are taken while the unit is idle; a byte that completes a
//   64-byte block starts 80 rounds through the single round unit, one round
//   per cycle, plus one chaining update, and no item is taken meanwhile.
//   A finish item feeds padding and length bytes one per cycle up to the end
//   of the block, then the block is compressed; if 56 or more bytes were
//   pending a second block is padded and compressed as well. The five words
//   then follow, one per cycle while rsp_tready is high.
// Reset: synchronous, active high; restores the initial chaining values and
//   clears the byte count. After each digest the unit restarts the same way.
// Stall: while rsp_tready is low the current digest word holds and no new
//   request is taken.

module sha1_byte_stream_hasher_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sha1bs_pkg::DATA_BYTE_W-1:0]  req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] action
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sha1bs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] digest_word,
                                                           // [34:32] word_index
   output logic                                rsp_tlast   // last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef sha1bs_pkg::word_type word_type;

   // Control registers
   state_type                                state_ff, state_in;
   logic [5:0]                               fill_ff, fill_in;
   logic [sha1bs_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic                                     pad_ff, pad_in;
   logic                                     zblk_ff, zblk_in;
   logic [6:0]                               rnd_ff, rnd_in;
   logic [sha1bs_pkg::WORD_INDEX_W-1:0]      idx_ff, idx_in;
   logic                                     out_valid_ff, out_valid_in;
   word_type                                 chain_ff [sha1bs_pkg::CHAIN_WORDS];
   word_type                                 chain_in [sha1bs_pkg::CHAIN_WORDS];

   // Payload registers
   logic [511:0]                             msg_ff, msg_in;
   word_type                                 a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type                                 a_in, b_in, c_in, d_in, e_in;
   word_type                                 out_word_ff, out_word_in;

   // Datapath helpers
   logic                                     req_fire;
   logic                                     rsp_fire;
   logic [63:0]                              len_bits;
   logic [7:0]                               len_byte;
   logic [7:0]                               pad_byte;
   word_type                                 w_cur, w_new;
   word_type                                 f_val, k_val, t_val;
   word_type                                 chain_sum [sha1bs_pkg::CHAIN_WORDS];
   logic [sha1bs_pkg::WORD_INDEX_W-1:0]      idx_nxt;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = out_valid_ff & rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (idx_ff == sha1bs_pkg::LAST_INDEX_C);
   assign rsp_tdata  = {5'b00000, idx_ff, out_word_ff};

   // Pick the padding byte: length bytes fill the last eight slots of the
   // final block, everything else is zero
   assign len_bits = {count_ff, 3'b000};
   assign len_byte = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
   assign pad_byte = (!zblk_ff && fill_ff[5:3] == 3'b111) ? len_byte : 8'h00;

   // Rolling schedule window: word 0 is the current word
   assign w_cur = msg_ff[511:480];
   always_comb begin
      word_type x;
      x     = msg_ff[95:64] ^ msg_ff[255:224] ^ msg_ff[447:416] ^ msg_ff[511:480];
      w_new = {x[30:0], x[31]};
   end

   // Round function and constant per group of twenty rounds
   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         k_val = sha1bs_pkg::K0_C;
      end else if (rnd_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1bs_pkg::K1_C;
      end else if (rnd_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         k_val = sha1bs_pkg::K2_C;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1bs_pkg::K3_C;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + w_cur + k_val;

   // Chaining update after the last round
   assign chain_sum[0] = chain_ff[0] + a_ff;
   assign chain_sum[1] = chain_ff[1] + b_ff;
   assign chain_sum[2] = chain_ff[2] + c_ff;
   assign chain_sum[3] = chain_ff[3] + d_ff;
   assign chain_sum[4] = chain_ff[4] + e_ff;

   assign idx_nxt = idx_ff + 3'd1;

   // Sequencer next-state logic
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      pad_in       = pad_ff;
      zblk_in      = zblk_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      chain_in     = chain_ff;
      msg_in       = msg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      out_word_in  = out_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fill_in = fill_ff + 6'd1;
               if (req_tuser == sha1bs_pkg::ACTION_ABSORB_C) begin
                  // Absorb: shift the byte in and count it
                  msg_in   = {msg_ff[503:0], req_tdata};
                  count_in = count_ff + 61'd1;
               end else begin
                  // Finish: place the marker byte, note a full trailing block
                  msg_in  = {msg_ff[503:0], sha1bs_pkg::PAD_BYTE_C};
                  pad_in  = 1'b1;
                  zblk_in = (fill_ff[5:3] == 3'b111);
                  state_in = ST_PAD;
               end
               if (fill_ff == 6'd63) begin
                  state_in = ST_ROUND;
                  rnd_in   = 7'd0;
                  a_in     = chain_ff[0];
                  b_in     = chain_ff[1];
                  c_in     = chain_ff[2];
                  d_in     = chain_ff[3];
                  e_in     = chain_ff[4];
               end
            end
         end
         ST_PAD: begin
            // Feed one padding or length byte a cycle until the block fills
            msg_in  = {msg_ff[503:0], pad_byte};
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = ST_ROUND;
               rnd_in   = 7'd0;
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
               e_in     = chain_ff[4];
            end
         end
         ST_ROUND: begin
            // One compression round a cycle; advance the schedule window
            msg_in = {msg_ff[479:0], w_new};
            a_in   = t_val;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha1bs_pkg::ROUNDS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            chain_in = chain_sum;
            priority if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (zblk_ff) begin
               zblk_in  = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in     = ST_EMIT;
               idx_in       = '0;
               out_word_in  = chain_sum[0];
               out_valid_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (idx_ff == sha1bs_pkg::LAST_INDEX_C) begin
                  // Last word taken: restart for a new message
                  out_valid_in = 1'b0;
                  chain_in     = sha1bs_pkg::H_INIT_C;
                  count_in     = '0;
                  pad_in       = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in      = idx_nxt;
                  out_word_in = chain_ff[idx_nxt];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         pad_ff       <= 1'b0;
         zblk_ff      <= 1'b0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         chain_ff     <= sha1bs_pkg::H_INIT_C;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         pad_ff       <= pad_in;
         zblk_ff      <= zblk_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Payload: block buffer / schedule window, working words, output word
   always_ff @(posedge clock) begin
      msg_ff      <= msg_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      out_word_ff <= out_word_in;
   end

endmodule

// File: rtl/core/sha1bs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1bs_checker
// Port-level checks of the SHA-1 byte stream hasher, bound to the top level.
// ============================================================================

module sha1bs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sha1bs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                                rsp_tlast
);

   // Hold a stalled digest word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled digest word changed");

   // Take no request while a digest is being sent
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken during digest output");

   // Mark the last word exactly at the final index
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == sha1bs_pkg::LAST_INDEX_C)))
      else $error("last marker and word index disagree");

   // Advance the word index by one after each word taken
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("digest word index skipped");

   // Drop ready right after a finish item
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == sha1bs_pkg::ACTION_FINISH_C) |=> !req_tready)
      else $error("ready after finish item");

endmodule

bind sha1_byte_stream_hasher_unit sha1bs_checker u_sha1bs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
